>>> hdl/asealu_pkg.sv
package asealu_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned HalfW = 32;
  localparam int unsigned FlagW = 4;
  localparam int unsigned KindW = 3;
  localparam int unsigned ShiftW = 3;

  typedef enum logic [1:0] {
    SZ_BYTE = 2'd0,
    SZ_HALF = 2'd1,
    SZ_WORD = 2'd2,
    SZ_DOUBLE = 2'd3
  } asealu_size_e;

  typedef enum logic {
    FUNC_ADD = 1'b0,
    FUNC_SUB = 1'b1
  } asealu_func_e;

  typedef struct packed {
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    logic cin;
    logic wide;
    logic fw;
  } asealu_prep_t;

  typedef struct packed {
    logic [HalfW-1:0] a_hi;
    logic [HalfW-1:0] b_hi;
    logic [HalfW-1:0] lo_sum;
    logic lo_carry;
    logic lo_zero;
    logic lo_ovf;
    logic wide;
    logic fw;
  } asealu_lo_t;

  typedef struct packed {
    logic [DataW-1:0] res;
    logic [FlagW-1:0] nzcv;
    logic fw;
  } asealu_res_t;

endpackage

>>> hdl/asealu_prep.sv
module asealu_prep
  import asealu_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  logic func_i,
  input  logic [DataW-1:0] first_operand_i,
  input  logic [DataW-1:0] second_operand_i,
  input  logic [KindW-1:0] extend_kind_i,
  input  logic [ShiftW-1:0] shift_left_i,
  input  logic wide_mode_i,
  input  logic set_flags_i,
  output logic valid_o,
  output asealu_prep_t data_o
);

  logic valid_q;
  asealu_prep_t data_d, data_q;
  logic [DataW-1:0] ext;
  logic [DataW-1:0] shifted;
  logic sgn;
  logic sub;

  always_comb begin
    sgn = extend_kind_i[2];
    unique case (asealu_size_e'(extend_kind_i[1:0]))
      SZ_BYTE: ext = {{(DataW-8){sgn & second_operand_i[7]}}, second_operand_i[7:0]};
      SZ_HALF: ext = {{(DataW-16){sgn & second_operand_i[15]}}, second_operand_i[15:0]};
      SZ_WORD: ext = {{(DataW-32){sgn & second_operand_i[31]}}, second_operand_i[31:0]};
      SZ_DOUBLE: ext = second_operand_i;
      default: ext = second_operand_i;
    endcase
    shifted = ext << shift_left_i;
    sub = (asealu_func_e'(func_i) == FUNC_SUB);
    data_d.a = first_operand_i;
    data_d.b = sub ? ~shifted : shifted;
    data_d.cin = sub;
    data_d.wide = wide_mode_i;
    data_d.fw = set_flags_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o = data_q;

endmodule

>>> hdl/asealu_add_lo.sv
module asealu_add_lo
  import asealu_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  asealu_prep_t data_i,
  output logic valid_o,
  output asealu_lo_t data_o
);

  logic valid_q;
  asealu_lo_t data_d, data_q;
  logic [HalfW:0] sum;

  always_comb begin
    sum = {1'b0, data_i.a[HalfW-1:0]} + {1'b0, data_i.b[HalfW-1:0]}
        + {{HalfW{1'b0}}, data_i.cin};
    data_d.a_hi = data_i.a[DataW-1:HalfW];
    data_d.b_hi = data_i.b[DataW-1:HalfW];
    data_d.lo_sum = sum[HalfW-1:0];
    data_d.lo_carry = sum[HalfW];
    data_d.lo_zero = (sum[HalfW-1:0] == '0);
    data_d.lo_ovf = (data_i.a[HalfW-1] ^ sum[HalfW-1]) & (data_i.b[HalfW-1] ^ sum[HalfW-1]);
    data_d.wide = data_i.wide;
    data_d.fw = data_i.fw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o = data_q;

endmodule

>>> hdl/asealu_add_hi.sv
module asealu_add_hi
  import asealu_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  asealu_lo_t data_i,
  output logic valid_o,
  output asealu_res_t data_o
);

  logic valid_q;
  asealu_res_t data_d, data_q;
  logic [HalfW:0] sum;
  logic ovf_hi;

  always_comb begin
    sum = {1'b0, data_i.a_hi} + {1'b0, data_i.b_hi} + {{HalfW{1'b0}}, data_i.lo_carry};
    ovf_hi = (data_i.a_hi[HalfW-1] ^ sum[HalfW-1]) & (data_i.b_hi[HalfW-1] ^ sum[HalfW-1]);
    if (data_i.wide) begin
      data_d.res = {sum[HalfW-1:0], data_i.lo_sum};
      data_d.nzcv = {sum[HalfW-1], data_i.lo_zero & (sum[HalfW-1:0] == '0),
                     sum[HalfW], ovf_hi};
    end else begin
      data_d.res = {{HalfW{1'b0}}, data_i.lo_sum};
      data_d.nzcv = {data_i.lo_sum[HalfW-1], data_i.lo_zero, data_i.lo_carry, data_i.lo_ovf};
    end
    data_d.fw = data_i.fw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o = data_q;

endmodule

>>> hdl/add_sub_extended_register_alu_top.sv
// Channel   Handshake                  Payload
// request   in_valid_i / in_stall_o    func, operands, extend, shift, width, set_flags
// result    out_valid_o / out_stall_i  result_value, flags_nzcv, flags_write
//
// Three register stages: an accepted request passes through the prep, low-add and
// high-add registers in that order before it shows as a valid result; one request per
// cycle is taken while the result side keeps up.
// Stages: operand extend and shift, low 32-bit add, high 32-bit add with flags.
// Reset clears the stage valid bits only.
// A stalled result holds the unbroken run of full stages behind it; stages behind a
// bubble still advance.
module add_sub_extended_register_alu_top
  import asealu_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic func_i,
  input  logic [DataW-1:0] first_operand_i,
  input  logic [DataW-1:0] second_operand_i,
  input  logic [KindW-1:0] extend_kind_i,
  input  logic [ShiftW-1:0] shift_left_i,
  input  logic wide_mode_i,
  input  logic set_flags_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic [DataW-1:0] result_value_o,
  output logic [FlagW-1:0] flags_nzcv_o,
  output logic flags_write_o
);

  logic en1, en2, en3;
  logic v1, v2, v3;
  asealu_prep_t s1;
  asealu_lo_t s2;
  asealu_res_t s3;

  assign en3 = !v3 || !out_stall_i;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_stall_o = !en1;

  asealu_prep u_prep (
    .clk_i,
    .rst_ni,
    .en_i(en1),
    .valid_i(in_valid_i),
    .func_i,
    .first_operand_i,
    .second_operand_i,
    .extend_kind_i,
    .shift_left_i,
    .wide_mode_i,
    .set_flags_i,
    .valid_o(v1),
    .data_o(s1)
  );

  asealu_add_lo u_add_lo (
    .clk_i,
    .rst_ni,
    .en_i(en2),
    .valid_i(v1),
    .data_i(s1),
    .valid_o(v2),
    .data_o(s2)
  );

  asealu_add_hi u_add_hi (
    .clk_i,
    .rst_ni,
    .en_i(en3),
    .valid_i(v2),
    .data_i(s2),
    .valid_o(v3),
    .data_o(s3)
  );

  assign out_valid_o = v3;
  assign result_value_o = s3.res;
  assign flags_nzcv_o = s3.nzcv;
  assign flags_write_o = s3.fw;

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1 && v2 && v3 && out_stall_i))
    else $error("request stalled with an empty stage");

  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (flags_nzcv_o[2] == (result_value_o == '0)))
    else $error("zero flag disagrees with result");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2 && !out_stall_i) |=> v3)
    else $error("item lost between add stages");

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import asealu_pkg::*;

  localparam int unsigned DirRows = 20;
  localparam int unsigned RandPerPhase = 610;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned DrainCycles = 8;

  typedef enum logic [KindW-1:0] {
    EXT_UXTB = 3'd0,
    EXT_UXTH = 3'd1,
    EXT_UXTW = 3'd2,
    EXT_UXTX = 3'd3,
    EXT_SXTB = 3'd4,
    EXT_SXTH = 3'd5,
    EXT_SXTW = 3'd6,
    EXT_SXTX = 3'd7
  } extend_kind_e;

  typedef struct packed {
    asealu_func_e func;
    logic [DataW-1:0] src_a;
    logic [DataW-1:0] src_b;
    extend_kind_e kind;
    logic [ShiftW-1:0] shamt;
    logic wide;
    logic setf;
  } alu_req_t;

  typedef struct packed {
    alu_req_t req;
    logic known;
    logic [DataW-1:0] res;
    logic [FlagW-1:0] nzcv;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic func_i = 1'b0;
  logic [DataW-1:0] first_operand_i = '0;
  logic [DataW-1:0] second_operand_i = '0;
  logic [KindW-1:0] extend_kind_i = '0;
  logic [ShiftW-1:0] shift_left_i = '0;
  logic wide_mode_i = 1'b0;
  logic set_flags_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [DataW-1:0] result_value_o;
  logic [FlagW-1:0] flags_nzcv_o;
  logic flags_write_o;

  asealu_res_t expected_sums[$];
  asealu_res_t sum_head;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned gap_by_phase[3] = '{34, 60, 0};
  int unsigned stall_by_phase[3] = '{60, 34, 0};

  dir_row_t dir_table[DirRows] = '{
    '{'{FUNC_ADD, 64'h0, 64'h0, EXT_UXTX, 3'd0, 1'b1, 1'b1}, 1'b1, 64'h0, 4'b0100},
    '{'{FUNC_SUB, 64'h0, 64'h0, EXT_UXTX, 3'd0, 1'b1, 1'b1}, 1'b1, 64'h0, 4'b0110},
    '{'{FUNC_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1, EXT_UXTX, 3'd0, 1'b1, 1'b1},
      1'b1, 64'h0, 4'b0110},
    '{'{FUNC_SUB, 64'h8000_0000_0000_0000, 64'h1, EXT_UXTX, 3'd0, 1'b1, 1'b1},
      1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 4'b0011},
    '{'{FUNC_ADD, 64'h7FFF_FFFF_FFFF_FFFF, 64'h1, EXT_UXTX, 3'd0, 1'b1, 1'b1},
      1'b1, 64'h8000_0000_0000_0000, 4'b1001},
    '{'{FUNC_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1, EXT_UXTB, 3'd0, 1'b0, 1'b1},
      1'b1, 64'h0, 4'b0110},
    '{'{FUNC_SUB, 64'h0, 64'h1, EXT_UXTB, 3'd0, 1'b0, 1'b1},
      1'b1, 64'h0000_0000_FFFF_FFFF, 4'b1000},
    '{'{FUNC_ADD, 64'h1, 64'h1, EXT_UXTX, 3'd0, 1'b1, 1'b0}, 1'b1, 64'h2, 4'b0000},
    '{'{FUNC_SUB, 64'hFFFF_FFFF_8000_0000, 64'h1, EXT_UXTW, 3'd0, 1'b0, 1'b1},
      1'b1, 64'h0000_0000_7FFF_FFFF, 4'b0011},
    '{'{FUNC_ADD, 64'h0, 64'h80, EXT_SXTB, 3'd0, 1'b1, 1'b1}, 1'b0, 64'h0, 4'h0},
    '{'{FUNC_ADD, 64'h1, 64'h8000, EXT_SXTH, 3'd1, 1'b1, 1'b1}, 1'b0, 64'h0, 4'h0},
    '{'{FUNC_SUB, 64'h0, 64'h8000_0000, EXT_SXTW, 3'd4, 1'b1, 1'b1}, 1'b0, 64'h0, 4'h0},
    '{'{FUNC_ADD, 64'h5, 64'hFFFF_FFFF_FFFF_FFFF, EXT_SXTX, 3'd2, 1'b0, 1'b1},
      1'b0, 64'h0, 4'h0},
    '{'{FUNC_ADD, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, EXT_UXTB, 3'd3, 1'b1, 1'b1},
      1'b0, 64'h0, 4'h0},
    '{'{FUNC_SUB, 64'h1234_5678_9ABC_DEF0, 64'hFFFF, EXT_UXTH, 3'd5, 1'b1, 1'b1},
      1'b0, 64'h0, 4'h0},
    '{'{FUNC_SUB, 64'hFFFF_0000_0000_0000, 64'hFFFF_FFFF, EXT_UXTW, 3'd6, 1'b0, 1'b1},
      1'b0, 64'h0, 4'h0},
    '{'{FUNC_ADD, 64'h8000_0000, 64'hDEAD_BEEF_8000_0000, EXT_UXTX, 3'd7, 1'b0, 1'b1},
      1'b0, 64'h0, 4'h0},
    '{'{FUNC_ADD, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7F, EXT_SXTB, 3'd4, 1'b1, 1'b0},
      1'b0, 64'h0, 4'h0},
    '{'{FUNC_SUB, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, EXT_SXTX, 3'd0, 1'b1,
      1'b1}, 1'b0, 64'h0, 4'h0},
    '{'{FUNC_SUB, 64'h0, 64'h8000, EXT_SXTH, 3'd4, 1'b0, 1'b1}, 1'b0, 64'h0, 4'h0}
  };

  add_sub_extended_register_alu_top dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .func_i(func_i),
    .first_operand_i(first_operand_i),
    .second_operand_i(second_operand_i),
    .extend_kind_i(extend_kind_i),
    .shift_left_i(shift_left_i),
    .wide_mode_i(wide_mode_i),
    .set_flags_i(set_flags_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .result_value_o(result_value_o),
    .flags_nzcv_o(flags_nzcv_o),
    .flags_write_o(flags_write_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic asealu_res_t predict_sum(input alu_req_t r);
    logic [DataW-1:0] opnd;
    logic [DataW-1:0] mask;
    logic [DataW:0] wide_sum;
    logic [HalfW:0] narrow_sum;
    logic carry_in;
    logic neg;
    logic zero;
    logic carry;
    logic ovf;
    int unsigned nbits;
    asealu_res_t o;
    opnd = r.src_b;
    nbits = 8 << r.kind[1:0];
    if (asealu_size_e'(r.kind[1:0]) != SZ_DOUBLE) begin
      mask = (64'd1 << nbits) - 64'd1;
      opnd = opnd & mask;
      if (r.kind[2] && opnd[nbits-1]) opnd = opnd | ~mask;
    end
    opnd = opnd << r.shamt;
    carry_in = (r.func == FUNC_SUB);
    if (carry_in) opnd = ~opnd;
    if (r.wide) begin
      wide_sum = {1'b0, r.src_a} + {1'b0, opnd} + {{DataW{1'b0}}, carry_in};
      o.res = wide_sum[DataW-1:0];
      neg = o.res[DataW-1];
      carry = wide_sum[DataW];
      ovf = (r.src_a[DataW-1] ^ o.res[DataW-1]) & (opnd[DataW-1] ^ o.res[DataW-1]);
    end else begin
      narrow_sum = {1'b0, r.src_a[HalfW-1:0]} + {1'b0, opnd[HalfW-1:0]}
                 + {{HalfW{1'b0}}, carry_in};
      o.res = {{(DataW-HalfW){1'b0}}, narrow_sum[HalfW-1:0]};
      neg = narrow_sum[HalfW-1];
      carry = narrow_sum[HalfW];
      ovf = (r.src_a[HalfW-1] ^ o.res[HalfW-1]) & (opnd[HalfW-1] ^ o.res[HalfW-1]);
    end
    zero = (o.res == '0);
    o.nzcv = {neg, zero, carry, ovf};
    o.fw = r.setf;
    return o;
  endfunction

  function automatic logic [DataW-1:0] pick_operand();
    unique case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return {1'b1, {(DataW-1){1'b0}}};
      3: return {1'b0, {(DataW-1){1'b1}}};
      4: return DataW'($urandom_range(255));
      5: return {32'($urandom), 32'hFFFF_FFFF};
      6: return {32'h0, 32'($urandom)};
      default: return {32'($urandom), 32'($urandom)};
    endcase
  endfunction

  function automatic alu_req_t random_request();
    alu_req_t r;
    r.func = asealu_func_e'($urandom_range(1));
    r.src_a = pick_operand();
    r.src_b = ($urandom_range(7) == 0) ? r.src_a : pick_operand();
    r.kind = extend_kind_e'($urandom_range(7));
    r.shamt = ($urandom_range(9) == 0) ? ShiftW'($urandom_range(7, 5))
                                       : ShiftW'($urandom_range(4));
    r.wide = 1'($urandom_range(1));
    r.setf = 1'($urandom_range(1));
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] want);
    $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic issue_request(input alu_req_t r, input asealu_res_t want);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    func_i <= r.func;
    first_operand_i <= r.src_a;
    second_operand_i <= r.src_b;
    extend_kind_i <= r.kind;
    shift_left_i <= r.shamt;
    wide_mode_i <= r.wide;
    set_flags_i <= r.setf;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    expected_sums.push_back(want);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_sums.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_sums.size() == 0) begin
        report_mismatch("result with no request pending", result_value_o, '0);
      end else begin
        sum_head = expected_sums.pop_front();
        if (result_value_o !== sum_head.res)
          report_mismatch("result_value", result_value_o, sum_head.res);
        if (flags_nzcv_o !== sum_head.nzcv)
          report_mismatch("flags_nzcv", DataW'(flags_nzcv_o), DataW'(sum_head.nzcv));
        if (flags_write_o !== sum_head.fw)
          report_mismatch("flags_write", DataW'(flags_write_o), DataW'(sum_head.fw));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("tb_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    alu_req_t req;
    asealu_res_t want;
    send_gap_pct = gap_by_phase[0];
    recv_stall_pct = stall_by_phase[0];
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DirRows; i++) begin
      req = dir_table[i].req;
      if (dir_table[i].known) begin
        want.res = dir_table[i].res;
        want.nzcv = dir_table[i].nzcv;
        want.fw = req.setf;
      end else begin
        want = predict_sum(req);
      end
      issue_request(req, want);
    end
    drain_results();

    for (int ph = 0; ph < 3; ph++) begin
      send_gap_pct = gap_by_phase[ph];
      recv_stall_pct = stall_by_phase[ph];
      for (int n = 0; n < RandPerPhase; n++) begin
        req = random_request();
        issue_request(req, predict_sum(req));
      end
      drain_results();
    end

    repeat (DrainCycles) @(negedge clk_i);
    if (mismatch_count == 0 && expected_sums.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
